/* rtl/failure_record_prune_matcher_unit_assert.svh */
// Assertion macros used by the failure record prune matcher RTL.
`ifndef FAILURE_RECORD_PRUNE_MATCHER_UNIT_ASSERT_SVH
`define FAILURE_RECORD_PRUNE_MATCHER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on aclk and disabled in reset.
`define FRPM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk and disabled in reset.
`define FRPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/frpm_pkg.sv */
// Types and constants of the failure record prune matcher.
`timescale 1ns / 1ps
package frpm_pkg;

    localparam int CMD_W     = 3;
    localparam int ROBOT_W   = 6;
    localparam int SPECIES_W = 4;
    localparam int TASK_W    = 6;
    localparam int KEY_W     = 6;
    localparam int MASK_W    = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY            = 3'd0,
        CMD_ADD_ROBOT_TASK   = 3'd1,
        CMD_ADD_ROBOT_PAIR   = 3'd2,
        CMD_ADD_SPECIES_TASK = 3'd3,
        CMD_ADD_SPECIES_PAIR = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_ROBOT_TASK   = 2'd0,
        KIND_ROBOT_PAIR   = 2'd1,
        KIND_SPECIES_TASK = 2'd2,
        KIND_SPECIES_PAIR = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [KEY_W-1:0]  key;
        logic [TASK_W-1:0] first_task;
        logic [TASK_W-1:0] second_task;
    } record_t;

    typedef struct packed {
        logic [ROBOT_W-1:0]   robot;
        logic [SPECIES_W-1:0] species;
        logic [TASK_W-1:0]    task_id;
        logic [MASK_W-1:0]    mask;
    } query_t;

    typedef struct packed {
        logic clear;
        logic enable;
    } match_ctrl_t;

endpackage

/* rtl/frpm_table.sv */
// Record store: one write port and one registered read port.
`timescale 1ns / 1ps
module frpm_table #(
    parameter int ENTRIES = 64
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
    input  frpm_pkg::record_t                           wr_data,
    input  logic                                        rd_en,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
    output frpm_pkg::record_t                           rd_data
);
    import frpm_pkg::*;

    record_t mem [ENTRIES];
    record_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/frpm_match.sv */
// Shared record compare unit with a sticky hit accumulator.
`timescale 1ns / 1ps
module frpm_match (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  frpm_pkg::match_ctrl_t ctrl,
    input  frpm_pkg::query_t      query,
    input  frpm_pkg::record_t     record,
    output logic                  hit
);
    import frpm_pkg::*;

    logic is_robot;
    logic key_hit;
    logic rec_hit;
    logic hit_reg;
    logic hit_next;

    always_comb begin
        is_robot = (record.kind == KIND_ROBOT_TASK) || (record.kind == KIND_ROBOT_PAIR);
        key_hit  = is_robot ? (record.key == KEY_W'(query.robot))
                            : (record.key == KEY_W'(query.species));
        case (record.kind)
            KIND_ROBOT_TASK, KIND_SPECIES_TASK: begin
                rec_hit = key_hit && (record.first_task == query.task_id);
            end
            KIND_ROBOT_PAIR, KIND_SPECIES_PAIR: begin
                // Either task of the pair may be the new one; the other must be held.
                rec_hit = key_hit &&
                          (((record.first_task == query.task_id) &&
                            query.mask[record.second_task]) ||
                           ((record.second_task == query.task_id) &&
                            query.mask[record.first_task]));
            end
            default: begin
                rec_hit = 1'b0;
            end
        endcase
    end

    always_comb begin
        hit_next = hit_reg;
        if (ctrl.clear) begin
            hit_next = 1'b0;
        end else if (ctrl.enable) begin
            hit_next = hit_reg | rec_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

/* rtl/failure_record_prune_matcher_unit.sv */
// Top level of the failure record prune matcher: sequencer, record count and output register.
`timescale 1ns / 1ps
// Usage
// The s_ channel carries one request per accepted item: a query (command 0) or an
// insert of a robot-task, robot-pair, species-task or species-pair failure record.
// The m_ channel returns exactly one result per request: m_prune for queries and
// m_overflow for inserts that found the table full. Both channels are valid/ready.
// An insert is written into the record memory at the accepting edge. Its result
// passes through the finish state into the output register, and s_ready is high again
// from that same edge; no new request is taken before then. A query scans the
// stored records one per cycle through a single compare unit fed by the memory's
// registered read port. The scan states are followed by a drain state for the last
// record and the finish state, which registers the result; the next request can be
// accepted only after that. A root query, or a query against an empty table,
// finishes like an insert. An unused command code returns zeros.
// Reset clears the record count and all control state; record contents are not
// cleared and need no clearing pass. A finished result waits in the output
// register while the next request is accepted and processed; only when a second
// result is ready while the first still stalls does the sequencer hold, and s_ready
// stays low until the receiver takes the waiting result.
module failure_record_prune_matcher_unit #(
    parameter int ENTRIES = 64,
    parameter int TASKS   = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [frpm_pkg::CMD_W-1:0]          s_command,
    input  logic [frpm_pkg::ROBOT_W-1:0]        s_robot,
    input  logic [frpm_pkg::SPECIES_W-1:0]      s_species,
    input  logic [frpm_pkg::TASK_W-1:0]         s_task_req,
    input  logic [frpm_pkg::TASK_W-1:0]         s_other_task,
    input  logic [frpm_pkg::MASK_W-1:0]         s_assigned_mask,
    input  logic                                s_has_assignment,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_prune,
    output logic                                m_overflow
);
    import frpm_pkg::*;
    `include "failure_record_prune_matcher_unit_assert.svh"

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    // Mask bits for tasks beyond the configured range read as clear.
    localparam logic [MASK_W-1:0] TASK_LIMIT =
        (TASKS >= MASK_W) ? {MASK_W{1'b1}} : ((64'd1 << TASKS) - 64'd1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              ovf_reg, ovf_next;
    query_t            query_reg, query_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_prune_reg, m_prune_next;
    logic              m_overflow_reg, m_overflow_next;

    logic              wr_en;
    record_t           wr_rec;
    logic              rd_en;
    record_t           rd_rec;
    match_ctrl_t       match_ctrl;
    logic              hit;
    logic              table_full;
    logic              scan_last;
    logic              is_pair;
    logic              is_robot;

    assign s_ready    = (state_reg == ST_IDLE);
    assign table_full = (count_reg == CNT_W'(ENTRIES));
    assign scan_last  = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg);

    // Record image built from the request fields for an insert.
    always_comb begin
        is_pair  = 1'b0;
        is_robot = 1'b0;
        wr_rec.kind = KIND_ROBOT_TASK;
        case (cmd_t'(s_command))
            CMD_ADD_ROBOT_TASK: begin
                wr_rec.kind = KIND_ROBOT_TASK;
                is_robot    = 1'b1;
            end
            CMD_ADD_ROBOT_PAIR: begin
                wr_rec.kind = KIND_ROBOT_PAIR;
                is_robot    = 1'b1;
                is_pair     = 1'b1;
            end
            CMD_ADD_SPECIES_TASK: begin
                wr_rec.kind = KIND_SPECIES_TASK;
            end
            CMD_ADD_SPECIES_PAIR: begin
                wr_rec.kind = KIND_SPECIES_PAIR;
                is_pair     = 1'b1;
            end
            default: begin
                wr_rec.kind = KIND_ROBOT_TASK;
            end
        endcase
        wr_rec.key         = is_robot ? KEY_W'(s_robot) : KEY_W'(s_species);
        wr_rec.first_task  = s_task_req;
        wr_rec.second_task = is_pair ? s_other_task : '0;
    end

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        rd_valid_next   = 1'b0;
        ovf_next        = ovf_reg;
        query_next      = query_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_prune_next    = m_prune_reg;
        m_overflow_next = m_overflow_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        match_ctrl      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    query_next.robot   = s_robot;
                    query_next.species = s_species;
                    query_next.task_id = s_task_req;
                    query_next.mask    = s_assigned_mask & TASK_LIMIT;
                    match_ctrl.clear   = 1'b1;
                    ovf_next           = 1'b0;
                    scan_idx_next      = '0;
                    state_next         = ST_FINISH;
                    case (cmd_t'(s_command))
                        CMD_QUERY: begin
                            if (s_has_assignment && (count_reg != '0)) begin
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_ADD_ROBOT_TASK, CMD_ADD_ROBOT_PAIR,
                        CMD_ADD_SPECIES_TASK, CMD_ADD_SPECIES_PAIR: begin
                            if (table_full) begin
                                ovf_next = 1'b1;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                rd_en         = 1'b1;
                rd_valid_next = 1'b1;
                if (scan_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                // The last record read is compared on this cycle.
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_prune_next    = hit;
                    m_overflow_next = ovf_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        match_ctrl.enable = rd_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            ovf_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            rd_valid_reg <= rd_valid_next;
            ovf_reg      <= ovf_next;
            m_valid_reg  <= m_valid_next;
        end
        query_reg      <= query_next;
        m_prune_reg    <= m_prune_next;
        m_overflow_reg <= m_overflow_next;
    end

    frpm_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_rec),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_rec)
    );

    frpm_match u_match (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (match_ctrl),
        .query   (query_reg),
        .record  (rd_rec),
        .hit     (hit)
    );

    assign m_valid    = m_valid_reg;
    assign m_prune    = m_prune_reg;
    assign m_overflow = m_overflow_reg;

    `FRPM_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(ENTRIES), "record count past capacity")
    `FRPM_ASSERT_NEXT(a_count_stable_scan, state_reg == ST_SCAN, $stable(count_reg), "count moved during scan")
    `FRPM_ASSERT_NOW(a_read_from_scan, rd_valid_reg, $past(state_reg == ST_SCAN), "read data without a scan")
    `FRPM_ASSERT_NOW(a_result_from_finish, $rose(m_valid_reg), $past(state_reg == ST_FINISH), "result outside finish")
    `FRPM_ASSERT_NOW(a_flags_exclusive, m_valid_reg, !(m_prune_reg && m_overflow_reg), "prune and overflow together")

endmodule

/* tb/failure_record_prune_matcher_unit_tb.sv */
// Self-checking testbench for the failure record prune matcher: directed table, then random requests.
`timescale 1ns / 1ps
module failure_record_prune_matcher_unit_tb;
    import frpm_pkg::*;

    // Table depth of the block under test; the record store below mirrors it.
    localparam int ENTRIES = 64;

    // The watchdog gives up after this many cycles without any handshake. The slowest
    // legal gap is a full-table scan plus the longest sender gap and the longest
    // receiver stall, so this leaves a wide margin.
    localparam int STALL_LIMIT = 2000;

    // Number of random requests that count toward the run; unused codes do not count.
    localparam int RANDOM_REQUESTS = 530;
    // Past this count both sides stop idling.
    localparam int QUIET_TAIL_START = 470;

    // Command codes above the last insert; the block ignores them and answers zeros.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

    localparam logic [MASK_W-1:0] MASK_NONE  = '0;
    localparam logic [MASK_W-1:0] MASK_ALL   = '1;
    localparam logic [MASK_W-1:0] MASK_LOW   = 64'h0000_0000_0000_0001;
    localparam logic [MASK_W-1:0] MASK_TOP   = 64'h8000_0000_0000_0000;
    localparam logic [MASK_W-1:0] MASK_BIT31 = 64'h0000_0000_8000_0000;

    // One request on the s_ channel, field for field.
    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [ROBOT_W-1:0]   robot;
        logic [SPECIES_W-1:0] species;
        logic [TASK_W-1:0]    task_req;
        logic [TASK_W-1:0]    other_task;
        logic [MASK_W-1:0]    assigned_mask;
        logic                 has_assignment;
    } request_t;

    // One result on the m_ channel.
    typedef struct packed {
        logic prune;
        logic overflow;
    } verdict_t;

    // A row of the directed table. When fixed is set, the verdict typed into the row is
    // the expectation; otherwise the prune predictor supplies it.
    typedef struct packed {
        request_t req;
        logic     fixed;
        verdict_t want;
    } directed_row_t;

    localparam logic     FIXED   = 1'b1;
    localparam logic     PREDICT = 1'b0;
    localparam verdict_t ZEROS   = '0;

    localparam int NUM_DIRECTED = 22;

    // Fields: command, robot, species, task_req, other_task, assigned_mask, has_assignment.
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        // A query against the empty table can never prune.
        '{'{CMD_QUERY, 6'd0, 4'd0, 6'd0, 6'd0, MASK_ALL, 1'b1}, FIXED, ZEROS},
        // Unused command codes, with every field at its maximum or at zero, are ignored.
        '{'{CMD_SPARE_LO, 6'd63, 4'd15, 6'd63, 6'd63, MASK_ALL, 1'b1}, FIXED, ZEROS},
        '{'{CMD_SPARE_MID, 6'd63, 4'd15, 6'd63, 6'd63, MASK_ALL, 1'b1}, FIXED, ZEROS},
        '{'{CMD_SPARE_HI, 6'd0, 4'd0, 6'd0, 6'd0, MASK_NONE, 1'b0}, FIXED, ZEROS},
        // One insert of each kind at the key and task extremes; the table has room.
        '{'{CMD_ADD_ROBOT_TASK, 6'd63, 4'd0, 6'd63, 6'd0, MASK_NONE, 1'b0}, FIXED, ZEROS},
        '{'{CMD_ADD_ROBOT_PAIR, 6'd0, 4'd15, 6'd0, 6'd63, MASK_ALL, 1'b1}, FIXED, ZEROS},
        '{'{CMD_ADD_SPECIES_TASK, 6'd0, 4'd15, 6'd0, 6'd63, MASK_NONE, 1'b0}, FIXED, ZEROS},
        // A pair that names the same task twice.
        '{'{CMD_ADD_SPECIES_PAIR, 6'd63, 4'd0, 6'd63, 6'd63, MASK_NONE, 1'b0}, FIXED, ZEROS},
        // A duplicate record is stored again and must not change any answer.
        '{'{CMD_ADD_ROBOT_TASK, 6'd63, 4'd0, 6'd63, 6'd0, MASK_NONE, 1'b0}, FIXED, ZEROS},
        // Single robot record: hit, then the same query as a root, then a wrong robot.
        '{'{CMD_QUERY, 6'd63, 4'd0, 6'd63, 6'd0, MASK_NONE, 1'b1}, PREDICT, ZEROS},
        '{'{CMD_QUERY, 6'd63, 4'd0, 6'd63, 6'd0, MASK_ALL, 1'b0}, FIXED, ZEROS},
        '{'{CMD_QUERY, 6'd62, 4'd0, 6'd63, 6'd0, MASK_NONE, 1'b1}, PREDICT, ZEROS},
        // Robot pair matched from either end, and missed with the partner bit clear.
        '{'{CMD_QUERY, 6'd0, 4'd1, 6'd0, 6'd0, MASK_TOP, 1'b1}, PREDICT, ZEROS},
        '{'{CMD_QUERY, 6'd0, 4'd1, 6'd63, 6'd0, MASK_LOW, 1'b1}, PREDICT, ZEROS},
        '{'{CMD_QUERY, 6'd0, 4'd1, 6'd0, 6'd0, ~MASK_TOP, 1'b1}, PREDICT, ZEROS},
        // Species single record matched through the species field alone.
        '{'{CMD_QUERY, 6'd5, 4'd15, 6'd0, 6'd0, MASK_NONE, 1'b1}, PREDICT, ZEROS},
        // Same-task pair: hits only while that task's own bit is set.
        '{'{CMD_QUERY, 6'd1, 4'd0, 6'd63, 6'd0, MASK_TOP, 1'b1}, PREDICT, ZEROS},
        '{'{CMD_QUERY, 6'd1, 4'd0, 6'd63, 6'd0, ~MASK_TOP, 1'b1}, PREDICT, ZEROS},
        '{'{CMD_QUERY, 6'd63, 4'd15, 6'd62, 6'd0, MASK_ALL, 1'b1}, PREDICT, ZEROS},
        // A species pair inserted with a robot value that must be ignored.
        '{'{CMD_ADD_SPECIES_PAIR, 6'd63, 4'd15, 6'd31, 6'd32, MASK_ALL, 1'b1}, FIXED, ZEROS},
        '{'{CMD_QUERY, 6'd9, 4'd15, 6'd32, 6'd0, MASK_BIT31, 1'b1}, PREDICT, ZEROS},
        '{'{CMD_QUERY, 6'd63, 4'd0, 6'd0, 6'd0, MASK_ALL, 1'b1}, PREDICT, ZEROS}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_command;
    logic [ROBOT_W-1:0]   s_robot;
    logic [SPECIES_W-1:0] s_species;
    logic [TASK_W-1:0]    s_task_req;
    logic [TASK_W-1:0]    s_other_task;
    logic [MASK_W-1:0]    s_assigned_mask;
    logic                 s_has_assignment;
    logic                 m_valid;
    logic                 m_ready = 1'b1;
    logic                 m_prune;
    logic                 m_overflow;

    // Mirror of the block's failure table, filled in acceptance order.
    record_t failure_log [ENTRIES];
    int      failure_count = 0;

    // Verdicts still owed by the block, oldest first.
    verdict_t expected_verdicts [$];

    int fail_count   = 0;
    int stall_cycles = 0;
    // Chance in percent that either side starts an idle burst; changed per phase.
    int idle_pct     = 0;
    int ready_hold   = 0;

    failure_record_prune_matcher_unit #(
        .ENTRIES(ENTRIES)
    ) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_robot          (s_robot),
        .s_species        (s_species),
        .s_task_req       (s_task_req),
        .s_other_task     (s_other_task),
        .s_assigned_mask  (s_assigned_mask),
        .s_has_assignment (s_has_assignment),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_prune          (m_prune),
        .m_overflow       (m_overflow)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Works out the verdict for one accepted request and applies its effect on the
    // mirrored table. A query with an assignment prunes when a single record has the
    // right key and task, or a pair record has the right key, one task equal to the
    // query task and the other task set in the mask. An insert lands in the next free
    // slot, or is dropped with overflow when all slots are taken.
    function automatic verdict_t predict_verdict(input request_t r);
        verdict_t v;
        record_t  rec;
        logic     robot_keyed;
        logic     key_hit;
        v = '0;
        if (r.command == CMD_QUERY) begin
            if (r.has_assignment) begin
                for (int i = 0; i < failure_count; i++) begin
                    rec = failure_log[i];
                    robot_keyed = (rec.kind == KIND_ROBOT_TASK) || (rec.kind == KIND_ROBOT_PAIR);
                    key_hit = robot_keyed ? (rec.key == r.robot)
                                          : (rec.key == KEY_W'(r.species));
                    if (key_hit) begin
                        if (rec.kind == KIND_ROBOT_TASK || rec.kind == KIND_SPECIES_TASK) begin
                            if (rec.first_task == r.task_req)
                                v.prune = 1'b1;
                        end else if ((rec.first_task == r.task_req
                                      && r.assigned_mask[rec.second_task])
                                     || (rec.second_task == r.task_req
                                      && r.assigned_mask[rec.first_task])) begin
                            v.prune = 1'b1;
                        end
                    end
                end
            end
        end else if (r.command <= CMD_ADD_SPECIES_PAIR) begin
            if (failure_count >= ENTRIES) begin
                v.overflow = 1'b1;
            end else begin
                case (r.command)
                    CMD_ADD_ROBOT_TASK:   rec.kind = KIND_ROBOT_TASK;
                    CMD_ADD_ROBOT_PAIR:   rec.kind = KIND_ROBOT_PAIR;
                    CMD_ADD_SPECIES_TASK: rec.kind = KIND_SPECIES_TASK;
                    default:              rec.kind = KIND_SPECIES_PAIR;
                endcase
                robot_keyed = (rec.kind == KIND_ROBOT_TASK) || (rec.kind == KIND_ROBOT_PAIR);
                rec.key = robot_keyed ? r.robot : KEY_W'(r.species);
                rec.first_task = r.task_req;
                rec.second_task = (rec.kind == KIND_ROBOT_PAIR || rec.kind == KIND_SPECIES_PAIR)
                                  ? r.other_task : '0;
                failure_log[failure_count] = rec;
                failure_count++;
            end
        end
        return v;
    endfunction

    // Presents one request, possibly after an idle burst, and holds it until the block
    // takes it. The ready seen right after the edge is the value the block sampled at
    // that edge, since all drives here land in the nonblocking region. Valid is only
    // lowered when a gap is inserted, so back-to-back requests keep it high throughout.
    task automatic send_request(input request_t r, input logic fixed, input verdict_t want);
        verdict_t predicted;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_command        <= r.command;
        s_robot          <= r.robot;
        s_species        <= r.species;
        s_task_req       <= r.task_req;
        s_other_task     <= r.other_task;
        s_assigned_mask  <= r.assigned_mask;
        s_has_assignment <= r.has_assignment;
        do @(posedge aclk); while (s_ready !== 1'b1);
        // The predictor always runs so that the mirrored table tracks every insert.
        predicted = predict_verdict(r);
        expected_verdicts.push_back(fixed ? want : predicted);
    endtask

    // Receiver: stalls in bursts of random length at the phase's idle rate.
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            m_ready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            m_ready <= 1'b0;
            ready_hold <= int'($urandom_range(3));
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Each accepted result is checked against the oldest verdict owed.
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: result with no request waiting, expected none, %s %0b %s %0b",
                         $time, "got prune", m_prune, "overflow", m_overflow);
                fail_count++;
            end else begin
                want = expected_verdicts.pop_front();
                if (m_prune !== want.prune) begin
                    $display("%0t: prune mismatch, expected %0b, got %0b",
                             $time, want.prune, m_prune);
                    fail_count++;
                end
                if (m_overflow !== want.overflow) begin
                    $display("%0t: overflow mismatch, expected %0b, got %0b",
                             $time, want.overflow, m_overflow);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: any handshake on either channel restarts the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        int counted;
        int roll;
        int fill_pct;
        request_t r;
        record_t  rec;
        logic     pick_second;
        logic [TASK_W-1:0] partner;

        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_command        <= CMD_QUERY;
        s_robot          <= '0;
        s_species        <= '0;
        s_task_req       <= '0;
        s_other_task     <= '0;
        s_assigned_mask  <= '0;
        s_has_assignment <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: the table walked in order, with moderate idling on both sides.
        idle_pct = 20;
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].want);

        // Random part. Most queries are aimed at a stored record, with the partner bit
        // of a pair forced on or off and an occasional near miss on key or task, so
        // that both answers show up often. Inserts keep coming after the table fills
        // to exercise the overflow path against a full table.
        counted = 0;
        while (counted < RANDOM_REQUESTS) begin
            if (counted >= QUIET_TAIL_START) begin
                idle_pct = 0;
            end else if (counted % 40 == 0) begin
                case ($urandom_range(2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end

            r.command        = CMD_QUERY;
            r.robot          = ROBOT_W'($urandom);
            r.species        = SPECIES_W'($urandom);
            r.task_req       = TASK_W'($urandom);
            r.other_task     = TASK_W'($urandom);
            r.assigned_mask  = {$urandom, $urandom};
            r.has_assignment = ($urandom_range(9) != 0);

            fill_pct = (failure_count < ENTRIES) ? 25 : 12;
            roll = int'($urandom_range(99));
            if (roll < 4) begin
                // Unused code: ignored by the block, not counted.
                r.command = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            end else if (roll < 4 + fill_pct) begin
                r.command = CMD_W'($urandom_range(CMD_ADD_ROBOT_TASK, CMD_ADD_SPECIES_PAIR));
                counted++;
            end else begin
                if (failure_count > 0 && $urandom_range(99) < 65) begin
                    rec = failure_log[$urandom_range(failure_count - 1)];
                    if (rec.kind == KIND_ROBOT_TASK || rec.kind == KIND_ROBOT_PAIR)
                        r.robot = rec.key;
                    else
                        r.species = rec.key[SPECIES_W-1:0];
                    pick_second = 1'($urandom_range(1));
                    r.task_req = pick_second ? rec.second_task : rec.first_task;
                    partner    = pick_second ? rec.first_task : rec.second_task;
                    case ($urandom_range(3))
                        0:       r.assigned_mask[partner] = 1'b0;
                        1, 2:    r.assigned_mask[partner] = 1'b1;
                        default: ;
                    endcase
                    if ($urandom_range(7) == 0)
                        r.task_req = r.task_req ^ (TASK_W'(1) << $urandom_range(TASK_W - 1));
                    if ($urandom_range(9) == 0)
                        r.robot = r.robot ^ ROBOT_W'(1);
                end else begin
                    case ($urandom_range(3))
                        0:       r.assigned_mask = MASK_NONE;
                        1:       r.assigned_mask = MASK_ALL;
                        default: ;
                    endcase
                end
                counted++;
            end
            send_request(r, PREDICT, ZEROS);
        end

        // Drain: valid drops right after the last acceptance, every owed verdict must
        // arrive, then allow one more full scan so that a stray extra result would
        // still be caught.
        s_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge aclk);
        repeat (ENTRIES + 8) @(posedge aclk);

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
